>>> sv/sbsh_pkg.sv
// Shared types, constants and round functions for the SHA-256 byte hasher.
// Used by sbsh_front, sbsh_queue, sbsh_core and sha256_byte_stream_hasher.
package sbsh_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int BLOCK_WORDS     = 16;
  localparam int HASH_WORDS      = 8;
  localparam int ROUNDS          = 64;
  localparam int COUNT_W         = 61;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;

  localparam logic [31:0] ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_HASH [HASH_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef logic [31:0] word_t;

  // 512-bit block plus final flag, from the front to the compression unit
  typedef struct packed {
    logic                         final_blk;
    logic [BLOCK_WORDS-1:0][31:0] words;
  } block_t;

  typedef enum logic [2:0] {
    F_BYTES,
    F_FLUSH,
    F_PAD,
    F_PUSH,
    F_LEN
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_ROUND,
    B_ADD,
    B_OUT
  } back_state_t;

  function automatic word_t big_sig0(word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sig1(word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sig0(word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sig1(word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

>>> sv/sbsh_front.sv
// Byte intake: packs message bytes big-endian into blocks and appends padding.
// Depends on sbsh_pkg; feeds whole blocks to sbsh_queue.
module sbsh_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [7:0]      in_tdata,   // [7:0] data_byte
  input  logic            in_tuser,   // [0] has_byte
  input  logic            in_tlast,
  output logic            push_valid,
  input  logic            push_ready,
  output sbsh_pkg::block_t push_block
);

  sbsh_pkg::front_state_t      state_r, state_nxt;
  sbsh_pkg::word_t             buf_r [sbsh_pkg::BLOCK_WORDS];
  logic [sbsh_pkg::COUNT_W-1:0] count_r;
  logic                        last_r;
  logic                        final_r;
  logic                        accept;
  logic [5:0]                  pos;
  logic [3:0]                  wi;
  logic [1:0]                  lane;
  logic [63:0]                 bit_len;

  // Place one byte into its lane; the first lane starts a fresh word
  function automatic sbsh_pkg::word_t put_byte(sbsh_pkg::word_t old, logic [1:0] ln,
                                              logic [7:0] b);
    sbsh_pkg::word_t res;
    unique case (ln)
      2'd0:    res = {b, 24'h0};
      2'd1:    res = {old[31:24], b, 16'h0};
      2'd2:    res = {old[31:16], b, 8'h0};
      default: res = {old[31:8], b};
    endcase
    return res;
  endfunction

  assign pos     = count_r[5:0];
  assign wi      = pos[5:2];
  assign lane    = pos[1:0];
  assign bit_len = {count_r, 3'b000};
  assign accept  = in_tvalid && in_tready;

  // Next state and handshake outputs
  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    push_valid = 1'b0;
    unique case (state_r)
      sbsh_pkg::F_BYTES: begin
        in_tready = 1'b1;
        if (accept) begin
          if (in_tuser && pos == sbsh_pkg::LAST_POS) begin
            state_nxt = sbsh_pkg::F_FLUSH;
          end else if (in_tlast) begin
            state_nxt = sbsh_pkg::F_PAD;
          end
        end
      end
      sbsh_pkg::F_FLUSH: begin
        push_valid = 1'b1;
        if (push_ready) begin
          state_nxt = last_r ? sbsh_pkg::F_PAD : sbsh_pkg::F_BYTES;
        end
      end
      sbsh_pkg::F_PAD: begin
        state_nxt = sbsh_pkg::F_PUSH;
      end
      sbsh_pkg::F_PUSH: begin
        push_valid = 1'b1;
        if (push_ready) begin
          state_nxt = final_r ? sbsh_pkg::F_BYTES : sbsh_pkg::F_LEN;
        end
      end
      sbsh_pkg::F_LEN: begin
        state_nxt = sbsh_pkg::F_PUSH;
      end
      default: begin
        state_nxt = sbsh_pkg::F_BYTES;
      end
    endcase
  end

  // Hand the buffer out as a block
  always_comb begin
    push_block.final_blk = (state_r == sbsh_pkg::F_PUSH) && final_r;
    for (int i = 0; i < sbsh_pkg::BLOCK_WORDS; i++) begin
      push_block.words[sbsh_pkg::BLOCK_WORDS-1-i] = buf_r[i];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sbsh_pkg::F_BYTES;
      count_r <= '0;
      last_r  <= 1'b0;
      final_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        sbsh_pkg::F_BYTES: begin
          if (accept) begin
            last_r <= in_tlast;
            if (in_tuser) begin
              count_r <= count_r + 1'b1;
            end
          end
        end
        sbsh_pkg::F_PAD: begin
          final_r <= (pos < sbsh_pkg::LEN_POS);
        end
        sbsh_pkg::F_PUSH: begin
          if (push_ready && final_r) begin
            count_r <= '0;
          end
        end
        sbsh_pkg::F_LEN: begin
          final_r <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Block buffer: absorb bytes, pad, write the length
  always_ff @(posedge clk) begin
    unique case (state_r)
      sbsh_pkg::F_BYTES: begin
        if (accept && in_tuser) begin
          buf_r[wi] <= put_byte(buf_r[wi], lane, in_tdata);
        end
      end
      sbsh_pkg::F_PAD: begin
        for (int i = 0; i < sbsh_pkg::BLOCK_WORDS; i++) begin
          if (4'(i) == wi) begin
            buf_r[i] <= put_byte(buf_r[i], lane, sbsh_pkg::PAD_BYTE);
          end else if (4'(i) > wi) begin
            buf_r[i] <= '0;
          end
        end
        // length fits behind the pad in the same block
        if (pos < sbsh_pkg::LEN_POS) begin
          buf_r[sbsh_pkg::BLOCK_WORDS-2] <= bit_len[63:32];
          buf_r[sbsh_pkg::BLOCK_WORDS-1] <= bit_len[31:0];
        end
      end
      sbsh_pkg::F_LEN: begin
        for (int i = 0; i < sbsh_pkg::BLOCK_WORDS-2; i++) begin
          buf_r[i] <= '0;
        end
        buf_r[sbsh_pkg::BLOCK_WORDS-2] <= bit_len[63:32];
        buf_r[sbsh_pkg::BLOCK_WORDS-1] <= bit_len[31:0];
      end
      default: begin
      end
    endcase
  end

  // No new word is taken right after the end of a message
  a_pad_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_tlast |=> !in_tready)
    else $error("front accepted a word while padding was due");

  // The final block of a message clears the byte count
  a_count_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid && push_ready && push_block.final_blk |=> count_r == '0)
    else $error("byte count not cleared after final block");

endmodule

>>> sv/sbsh_queue.sv
// Short block queue between the byte front and the compression unit.
// Depends on sbsh_pkg for the block type.
module sbsh_queue #(
  parameter int DEPTH = sbsh_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  sbsh_pkg::block_t push_block,
  output logic             pop_valid,
  input  logic             pop_ready,
  output sbsh_pkg::block_t pop_block
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  sbsh_pkg::block_t   entry_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               push, pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_block  = entry_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= bump(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= bump(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Store the incoming block
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_block;
    end
  end

  a_fill_up: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + 1'b1)
    else $error("queue fill level did not follow a push");

endmodule

>>> sv/sbsh_core.sv
// Compression unit: one SHA-256 round per cycle, chaining words, digest output.
// Depends on sbsh_pkg for constants, round functions and the block type.
module sbsh_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  sbsh_pkg::block_t pop_block,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [39:0]      out_tdata,   // [31:0] digest_word, [34:32] word_index
  output logic             out_tlast    // final_word
);

  localparam logic [2:0] LAST_IDX   = 3'(sbsh_pkg::HASH_WORDS - 1);
  localparam logic [5:0] LAST_ROUND = 6'(sbsh_pkg::ROUNDS - 1);

  sbsh_pkg::back_state_t state_r, state_nxt;
  sbsh_pkg::word_t       win_r   [sbsh_pkg::BLOCK_WORDS];
  sbsh_pkg::word_t       v_r     [sbsh_pkg::HASH_WORDS];
  sbsh_pkg::word_t       chain_r [sbsh_pkg::HASH_WORDS];
  logic [5:0]            round_r;
  logic [2:0]            idx_r;
  logic                  final_r;
  logic                  out_fire;
  sbsh_pkg::word_t       t1, t2, ch, maj, w_new;

  assign pop_ready  = (state_r == sbsh_pkg::B_IDLE);
  assign out_tvalid = (state_r == sbsh_pkg::B_OUT);
  assign out_tdata  = {5'b0, idx_r, chain_r[idx_r]};
  assign out_tlast  = (idx_r == LAST_IDX);
  assign out_fire   = out_tvalid && out_tready;

  // Round datapath and next schedule word
  always_comb begin
    ch    = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    maj   = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t1    = v_r[7] + sbsh_pkg::big_sig1(v_r[4]) + ch + sbsh_pkg::ROUND_K[round_r] + win_r[0];
    t2    = sbsh_pkg::big_sig0(v_r[0]) + maj;
    w_new = sbsh_pkg::small_sig1(win_r[14]) + win_r[9]
          + sbsh_pkg::small_sig0(win_r[1]) + win_r[0];
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sbsh_pkg::B_IDLE: begin
        if (pop_valid) begin
          state_nxt = sbsh_pkg::B_ROUND;
        end
      end
      sbsh_pkg::B_ROUND: begin
        if (round_r == LAST_ROUND) begin
          state_nxt = sbsh_pkg::B_ADD;
        end
      end
      sbsh_pkg::B_ADD: begin
        state_nxt = final_r ? sbsh_pkg::B_OUT : sbsh_pkg::B_IDLE;
      end
      sbsh_pkg::B_OUT: begin
        if (out_fire && out_tlast) begin
          state_nxt = sbsh_pkg::B_IDLE;
        end
      end
      default: begin
        state_nxt = sbsh_pkg::B_IDLE;
      end
    endcase
  end

  // Control and chaining registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sbsh_pkg::B_IDLE;
      round_r <= '0;
      idx_r   <= '0;
      final_r <= 1'b0;
      for (int i = 0; i < sbsh_pkg::HASH_WORDS; i++) begin
        chain_r[i] <= sbsh_pkg::INIT_HASH[i];
      end
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        sbsh_pkg::B_IDLE: begin
          if (pop_valid) begin
            final_r <= pop_block.final_blk;
            round_r <= '0;
          end
        end
        sbsh_pkg::B_ROUND: begin
          round_r <= round_r + 1'b1;
        end
        sbsh_pkg::B_ADD: begin
          idx_r <= '0;
          for (int i = 0; i < sbsh_pkg::HASH_WORDS; i++) begin
            chain_r[i] <= chain_r[i] + v_r[i];
          end
        end
        sbsh_pkg::B_OUT: begin
          if (out_fire) begin
            idx_r <= idx_r + 1'b1;
            // reload the initial values once the digest is out
            if (out_tlast) begin
              for (int i = 0; i < sbsh_pkg::HASH_WORDS; i++) begin
                chain_r[i] <= sbsh_pkg::INIT_HASH[i];
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Schedule window and working variables
  always_ff @(posedge clk) begin
    unique case (state_r)
      sbsh_pkg::B_IDLE: begin
        if (pop_valid) begin
          for (int i = 0; i < sbsh_pkg::BLOCK_WORDS; i++) begin
            win_r[i] <= pop_block.words[sbsh_pkg::BLOCK_WORDS-1-i];
          end
          for (int i = 0; i < sbsh_pkg::HASH_WORDS; i++) begin
            v_r[i] <= chain_r[i];
          end
        end
      end
      sbsh_pkg::B_ROUND: begin
        for (int i = 0; i < sbsh_pkg::BLOCK_WORDS-1; i++) begin
          win_r[i] <= win_r[i+1];
        end
        win_r[sbsh_pkg::BLOCK_WORDS-1] <= w_new;
        v_r[7] <= v_r[6];
        v_r[6] <= v_r[5];
        v_r[5] <= v_r[4];
        v_r[4] <= v_r[3] + t1;
        v_r[3] <= v_r[2];
        v_r[2] <= v_r[1];
        v_r[1] <= v_r[0];
        v_r[0] <= t1 + t2;
      end
      default: begin
      end
    endcase
  end

  // Digest words leave in order
  a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && !out_tlast |=> out_tvalid && idx_r == $past(idx_r) + 3'd1)
    else $error("digest word index skipped");

  // Nothing follows the eighth word of a digest
  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && out_tlast |=> !out_tvalid)
    else $error("output still valid after final digest word");

endmodule

>>> sv/sha256_byte_stream_hasher.sv
// Top level of the SHA-256 byte-stream hasher: front, block queue, compression unit.
// Depends on sbsh_pkg, sbsh_front, sbsh_queue and sbsh_core.
//
// Channel   Dir  tdata                                   tuser      tlast
// in_       in   [7:0] data_byte                          has_byte   last
// out_      out  [31:0] digest_word, [34:32] word_index   -          final_word
//
// The front takes one byte per cycle while collecting bytes, but none while a
// full block is queued. Each block passes through the compression unit as load,
// 64 rounds and chain add; the unit takes a new block only when it is idle.
// After the last word, the front pads the message, then one or two blocks are
// compressed and the eight digest words follow, one per accepted cycle.
// Reset (rst_n low, synchronous) empties the queue and reloads the initial hash.
// The front stalls to pad and on a full queue; a stalled output holds the core.
module sha256_byte_stream_hasher #(
  parameter int QUEUE_DEPTH = sbsh_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte
  input  logic        in_tuser,    // [0] has_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,   // [31:0] digest_word, [34:32] word_index
  output logic        out_tlast
);

  logic             push_valid, push_ready;
  logic             pop_valid, pop_ready;
  sbsh_pkg::block_t push_block, pop_block;

  sbsh_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_block (push_block)
  );

  sbsh_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_block (push_block),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_block  (pop_block)
  );

  sbsh_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_block  (pop_block),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
